[sv/ahpe_pkg.sv]
// Shared constants, types and byte tables of the half-block pixel encoder.
package ahpe_pkg;

   localparam int MAX_WIDTH = 1024;
   localparam int MAX_ROWS  = 1024;
   localparam int MAX_PAD   = 16;

   localparam int DIM_W   = 11;
   localparam int PAD_W   = 5;
   localparam int CSR_IDX_W = 2;
   localparam int LANES   = 6;
   localparam int LANE_W  = 3;

   localparam logic [CSR_IDX_W-1:0] REG_ROW_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_COUNT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_PAD_SPACES = 2'd2;

   localparam logic [DIM_W-1:0] RESET_ROW_WIDTH  = 11'd80;
   localparam logic [DIM_W-1:0] RESET_ROW_COUNT  = 11'd24;
   localparam logic [PAD_W-1:0] RESET_PAD_SPACES = 5'd0;

   localparam logic [7:0] ESC_BYTE   = 8'h1B;
   localparam logic [7:0] SEMI_BYTE  = 8'h3B;
   localparam logic [7:0] SPACE_BYTE = 8'h20;
   localparam logic [7:0] ZERO_BYTE  = 8'h30;
   localparam logic [7:0] LF_BYTE    = 8'h0A;
   localparam logic [7:0] BLOCK_LAST_BYTE = 8'h80;

   typedef struct packed {
      logic [DIM_W-1:0] row_width;
      logic [DIM_W-1:0] row_count;
      logic [PAD_W-1:0] pad_spaces;
   } cfg_type;

   typedef struct packed {
      logic [2:0][3:0] dig;
      logic [1:0]      len;
   } lane_type;

   function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, logic [DIM_W-1:0] hi);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = 11'd1;
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

   // ESC [ H
   function automatic logic [7:0] home_byte(logic [2:0] i);
      logic [7:0] b;
      case (i)
         3'd0:    b = ESC_BYTE;
         3'd1:    b = 8'h5B;
         3'd2:    b = 8'h48;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // ESC [ 3 8 ; 2 ;
   function automatic logic [7:0] fg_byte(logic [2:0] i);
      logic [7:0] b;
      case (i)
         3'd0:    b = ESC_BYTE;
         3'd1:    b = 8'h5B;
         3'd2:    b = 8'h33;
         3'd3:    b = 8'h38;
         3'd4:    b = SEMI_BYTE;
         3'd5:    b = 8'h32;
         3'd6:    b = SEMI_BYTE;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // ; 4 8 ; 2 ;
   function automatic logic [7:0] bg_byte(logic [2:0] i);
      logic [7:0] b;
      case (i)
         3'd0:    b = SEMI_BYTE;
         3'd1:    b = 8'h34;
         3'd2:    b = 8'h38;
         3'd3:    b = SEMI_BYTE;
         3'd4:    b = 8'h32;
         3'd5:    b = SEMI_BYTE;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // m, then the upper half block
   function automatic logic [7:0] tail_byte(logic [2:0] i);
      logic [7:0] b;
      case (i)
         3'd0:    b = 8'h6D;
         3'd1:    b = 8'hE2;
         3'd2:    b = 8'h96;
         3'd3:    b = BLOCK_LAST_BYTE;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // ESC [ 0 m LF
   function automatic logic [7:0] eol_byte(logic [2:0] i);
      logic [7:0] b;
      case (i)
         3'd0:    b = ESC_BYTE;
         3'd1:    b = 8'h5B;
         3'd2:    b = 8'h30;
         3'd3:    b = 8'h6D;
         3'd4:    b = LF_BYTE;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

[sv/ahpe_req_if.sv]
// Pixel pair request channel.
interface ahpe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] top_red;
   logic [7:0] top_green;
   logic [7:0] top_blue;
   logic [7:0] bottom_red;
   logic [7:0] bottom_green;
   logic [7:0] bottom_blue;

   modport source (output valid, top_red, top_green, top_blue,
                   bottom_red, bottom_green, bottom_blue, input ready);
   modport sink   (input valid, top_red, top_green, top_blue,
                   bottom_red, bottom_green, bottom_blue, output ready);
endinterface

[sv/ahpe_rsp_if.sv]
// Terminal byte response channel.
interface ahpe_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       run_last;
   logic       frame_last;

   modport source (output valid, out_byte, run_last, frame_last, input ready);
   modport sink   (input valid, out_byte, run_last, frame_last, output ready);
endinterface

[sv/ahpe_csr_if.sv]
// Configuration register write channel.
interface ahpe_csr_if;
   logic                              valid;
   logic                              ready;
   logic [ahpe_pkg::CSR_IDX_W-1:0]    index;
   logic [ahpe_pkg::DIM_W-1:0]        data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[sv/ahpe_lane.sv]
// One color lane: splits a byte into decimal digits, most significant first.
module ahpe_lane (
   input  logic                clock,
   input  logic                load,
   input  logic [7:0]          value,
   output ahpe_pkg::lane_type  result_ff
);

   ahpe_pkg::lane_type result_in;
   logic [1:0]  hund;
   logic [7:0]  hund_val;
   logic [7:0]  rem;
   logic [14:0] prod;
   logic [3:0]  tens;
   logic [7:0]  tens_val;
   logic [3:0]  ones;

   always_comb begin
      if (value >= 8'd200) begin
         hund = 2'd2;
         hund_val = 8'd200;
      end else if (value >= 8'd100) begin
         hund = 2'd1;
         hund_val = 8'd100;
      end else begin
         hund = 2'd0;
         hund_val = 8'd0;
      end
      rem = value - hund_val;
      prod = 15'(rem[6:0]) * 15'd205;
      tens = prod[14:11];
      tens_val = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0};
      ones = 4'(rem - tens_val);

      if (value >= 8'd100) begin
         result_in.dig = {ones, tens, {2'b00, hund}};
         result_in.len = 2'd3;
      end else if (value >= 8'd10) begin
         result_in.dig = {4'd0, ones, tens};
         result_in.len = 2'd2;
      end else begin
         result_in.dig = {4'd0, 4'd0, ones};
         result_in.len = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result_in;
      end
   end

endmodule

[sv/ahpe_seq.sv]
// Byte sequencer: merges the lane digits and fixed text into the output stream.
module ahpe_seq (
   input  logic                                       clock,
   input  logic                                       reset,
   input  ahpe_pkg::cfg_type                          cfg,
   input  ahpe_pkg::lane_type [ahpe_pkg::LANES-1:0]   lanes,
   ahpe_req_if.sink                                   req_ch,
   ahpe_rsp_if.source                                 rsp_ch
);

   localparam logic [3:0] PH_IDLE = 4'd0;
   localparam logic [3:0] PH_HOME = 4'd1;
   localparam logic [3:0] PH_PAD  = 4'd2;
   localparam logic [3:0] PH_FG   = 4'd3;
   localparam logic [3:0] PH_DIG  = 4'd4;
   localparam logic [3:0] PH_SEP  = 4'd5;
   localparam logic [3:0] PH_BG   = 4'd6;
   localparam logic [3:0] PH_TAIL = 4'd7;
   localparam logic [3:0] PH_EOL  = 4'd8;

   logic [3:0]                       state_ff, state_in;
   logic [ahpe_pkg::PAD_W-1:0]       idx_ff, idx_in;
   logic [ahpe_pkg::LANE_W-1:0]      lane_ff, lane_in;
   logic [ahpe_pkg::PAD_W-1:0]       pad_ff, pad_in;
   logic                             line_end_ff, line_end_in;
   logic                             frame_end_ff, frame_end_in;
   logic [ahpe_pkg::DIM_W-1:0]       col_ff, col_in;
   logic [ahpe_pkg::DIM_W-1:0]       row_ff, row_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [7:0]                       byte_ff;
   logic                             run_last_ff;
   logic                             frame_last_ff;

   logic [ahpe_pkg::DIM_W-1:0]       width_eff;
   logic [ahpe_pkg::DIM_W-1:0]       height_eff;
   logic [ahpe_pkg::PAD_W-1:0]       pad_eff;
   logic                             line_end;
   logic                             frame_end;
   logic                             accept;
   logic                             advance;
   logic [7:0]                       byte_sel;
   logic                             last_sel;
   logic                             frame_sel;
   ahpe_pkg::lane_type               cur_lane;

   assign req_ch.ready = (state_ff == PH_IDLE);
   assign accept = req_ch.valid && req_ch.ready;
   assign advance = (state_ff != PH_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
   assign cur_lane = lanes[lane_ff];

   always_comb begin
      width_eff = ahpe_pkg::clamp_dim(cfg.row_width, 11'(ahpe_pkg::MAX_WIDTH));
      height_eff = ahpe_pkg::clamp_dim(cfg.row_count, 11'(ahpe_pkg::MAX_ROWS));
      pad_eff = (cfg.pad_spaces > 5'(ahpe_pkg::MAX_PAD)) ? 5'(ahpe_pkg::MAX_PAD)
                                                          : cfg.pad_spaces;
      line_end = ({1'b0, col_ff} + 12'd1) >= {1'b0, width_eff};
      frame_end = line_end && (({1'b0, row_ff} + 12'd1) >= {1'b0, height_eff});
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      lane_in = lane_ff;
      pad_in = pad_ff;
      line_end_in = line_end_ff;
      frame_end_in = frame_end_ff;
      col_in = col_ff;
      row_in = row_ff;
      byte_sel = 8'h00;
      last_sel = 1'b0;
      frame_sel = 1'b0;

      unique case (state_ff)
         PH_IDLE: begin
            if (accept) begin
               idx_in = '0;
               lane_in = '0;
               pad_in = (col_ff == '0) ? pad_eff : '0;
               line_end_in = line_end;
               frame_end_in = frame_end;
               if (col_ff == '0 && row_ff == '0) begin
                  state_in = PH_HOME;
               end else if (col_ff == '0 && pad_eff != '0) begin
                  state_in = PH_PAD;
               end else begin
                  state_in = PH_FG;
               end
               if (line_end) begin
                  col_in = '0;
                  row_in = frame_end ? '0 : row_ff + 11'd1;
               end else begin
                  col_in = col_ff + 11'd1;
               end
            end
         end
         PH_HOME: begin
            byte_sel = ahpe_pkg::home_byte(idx_ff[2:0]);
            if (advance) begin
               if (idx_ff == 5'd2) begin
                  idx_in = '0;
                  state_in = (pad_ff != '0) ? PH_PAD : PH_FG;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end
         PH_PAD: begin
            byte_sel = ahpe_pkg::SPACE_BYTE;
            if (advance) begin
               if (idx_ff + 5'd1 == pad_ff) begin
                  idx_in = '0;
                  state_in = PH_FG;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end
         PH_FG: begin
            byte_sel = ahpe_pkg::fg_byte(idx_ff[2:0]);
            if (advance) begin
               if (idx_ff == 5'd6) begin
                  idx_in = '0;
                  lane_in = '0;
                  state_in = PH_DIG;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end
         PH_DIG: begin
            byte_sel = ahpe_pkg::ZERO_BYTE + {4'd0, cur_lane.dig[idx_ff[1:0]]};
            if (advance) begin
               if (idx_ff[1:0] + 2'd1 == cur_lane.len) begin
                  idx_in = '0;
                  if (lane_ff == 3'd2) begin
                     state_in = PH_BG;
                  end else if (lane_ff == 3'(ahpe_pkg::LANES - 1)) begin
                     state_in = PH_TAIL;
                  end else begin
                     state_in = PH_SEP;
                  end
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end
         PH_SEP: begin
            byte_sel = ahpe_pkg::SEMI_BYTE;
            if (advance) begin
               lane_in = lane_ff + 3'd1;
               state_in = PH_DIG;
            end
         end
         PH_BG: begin
            byte_sel = ahpe_pkg::bg_byte(idx_ff[2:0]);
            if (advance) begin
               if (idx_ff == 5'd5) begin
                  idx_in = '0;
                  lane_in = 3'd3;
                  state_in = PH_DIG;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end
         PH_TAIL: begin
            byte_sel = ahpe_pkg::tail_byte(idx_ff[2:0]);
            last_sel = (idx_ff == 5'd3) && !line_end_ff;
            if (advance) begin
               if (idx_ff == 5'd3) begin
                  idx_in = '0;
                  state_in = line_end_ff ? PH_EOL : PH_IDLE;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end
         PH_EOL: begin
            byte_sel = ahpe_pkg::eol_byte(idx_ff[2:0]);
            last_sel = (idx_ff == 5'd4);
            frame_sel = (idx_ff == 5'd4) && frame_end_ff;
            if (advance) begin
               if (idx_ff == 5'd4) begin
                  idx_in = '0;
                  state_in = PH_IDLE;
               end else begin
                  idx_in = idx_ff + 5'd1;
               end
            end
         end
         default: begin
            state_in = PH_IDLE;
         end
      endcase
   end

   always_comb begin
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= PH_IDLE;
         idx_ff <= '0;
         lane_ff <= '0;
         pad_ff <= '0;
         line_end_ff <= 1'b0;
         frame_end_ff <= 1'b0;
         col_ff <= '0;
         row_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         lane_ff <= lane_in;
         pad_ff <= pad_in;
         line_end_ff <= line_end_in;
         frame_end_ff <= frame_end_in;
         col_ff <= col_in;
         row_ff <= row_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= byte_sel;
         run_last_ff <= last_sel;
         frame_last_ff <= frame_sel;
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.out_byte = byte_ff;
   assign rsp_ch.run_last = run_last_ff;
   assign rsp_ch.frame_last = frame_last_ff;

endmodule

[sv/ansi_halfblock_pixel_encoder_core.sv]
// Top level of the half-block pixel encoder: registers, color lanes, sequencer.
//
//   channel   dir   beat
//   req_ch    in    one pixel pair: top and bottom RGB bytes
//   rsp_ch    out   one terminal byte with run_last and frame_last
//   csr_ch    in    one register write: index and data
//
// The sequencer emits one byte per clock into the output register while rsp_ch
// does not stall.
// Reset clears the column and row counters and loads width 80, rows 24, pad 0.
// A stall on rsp_ch holds the sequencer; req_ch is ready between pixel pairs.
// csr_ch is always ready.
module ansi_halfblock_pixel_encoder_core (
   input  logic         clock,
   input  logic         reset,
   ahpe_req_if.sink     req_ch,
   ahpe_rsp_if.source   rsp_ch,
   ahpe_csr_if.sink     csr_ch
);

   ahpe_pkg::cfg_type                         cfg_ff, cfg_in;
   ahpe_pkg::lane_type [ahpe_pkg::LANES-1:0]  lane_res;
   logic [ahpe_pkg::LANES-1:0][7:0]           colors;
   logic                                      req_accept;

   assign csr_ch.ready = 1'b1;
   assign req_accept = req_ch.valid && req_ch.ready;
   assign colors = {req_ch.bottom_blue, req_ch.bottom_green, req_ch.bottom_red,
                    req_ch.top_blue, req_ch.top_green, req_ch.top_red};

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            ahpe_pkg::REG_ROW_WIDTH:  cfg_in.row_width = csr_ch.data;
            ahpe_pkg::REG_ROW_COUNT:  cfg_in.row_count = csr_ch.data;
            ahpe_pkg::REG_PAD_SPACES: cfg_in.pad_spaces = csr_ch.data[ahpe_pkg::PAD_W-1:0];
            default:                  cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_width <= ahpe_pkg::RESET_ROW_WIDTH;
         cfg_ff.row_count <= ahpe_pkg::RESET_ROW_COUNT;
         cfg_ff.pad_spaces <= ahpe_pkg::RESET_PAD_SPACES;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   for (genvar g = 0; g < ahpe_pkg::LANES; g++) begin : g_lane
      ahpe_lane u_lane (
         .clock     (clock),
         .load      (req_accept),
         .value     (colors[g]),
         .result_ff (lane_res[g])
      );
   end

   ahpe_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .lanes  (lane_res),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

[sv/ahpe_checker.sv]
// Port-level checker for the half-block pixel encoder, with its bind.
module ahpe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] out_byte,
   input logic       run_last,
   input logic       frame_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) &&
      $stable(run_last) && $stable(frame_last))
      else $error("rsp beat changed while stalled");

   a_frame_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && frame_last |-> run_last && out_byte == ahpe_pkg::LF_BYTE)
      else $error("frame_last not on the closing newline");

   a_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && run_last |->
      out_byte == ahpe_pkg::BLOCK_LAST_BYTE || out_byte == ahpe_pkg::LF_BYTE)
      else $error("run_last on an unexpected byte");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req beat taken while a pixel pair is in flight");

endmodule

bind ansi_halfblock_pixel_encoder_core ahpe_checker u_ahpe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .out_byte   (rsp_ch.out_byte),
   .run_last   (rsp_ch.run_last),
   .frame_last (rsp_ch.frame_last)
);
